FILE: rtl/playfair_digraph_encrypt_unit_macros.svh
// Assertion macros shared by the Playfair digraph encryptor RTL.
// Each macro expects clk and rst_n in scope in the module that uses it.
`ifndef PLAYFAIR_DIGRAPH_ENCRYPT_UNIT_MACROS_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPT_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PFD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pfd_pkg.sv
// Types, constants and helper functions for the Playfair digraph encryptor.
// No dependencies; imported by every other RTL file but the assertion macro header.
package pfd_pkg;

    localparam int SQUARE_SIDE = 5;
    localparam int LETTER_W    = 8;
    localparam int ROW_W       = SQUARE_SIDE * LETTER_W;
    localparam int SQ_IDX_W    = $clog2(SQUARE_SIDE);
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW4  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FILLER    = 3'd5;

    localparam logic [LETTER_W-1:0]  FILLER_RESET  = 8'd120;

    typedef logic [LETTER_W-1:0] letter_t;
    typedef logic [SQ_IDX_W-1:0] sq_idx_t;
    typedef logic [SQUARE_SIDE-1:0][LETTER_W-1:0] key_row_t;
    typedef logic [SQUARE_SIDE-1:0][SQUARE_SIDE-1:0][LETTER_W-1:0] square_t;

    typedef struct packed {
        letter_t first;
        letter_t second;
        logic    last;
    } pair_t;

    typedef struct packed {
        letter_t cipher_first;
        letter_t cipher_second;
        logic    not_in_square;
        logic    last_pair;
    } result_t;

    typedef struct packed {
        logic    hit;
        sq_idx_t row;
        sq_idx_t col;
    } loc_t;

    function automatic sq_idx_t wrap_inc(sq_idx_t v);
        sq_idx_t r;
        if (v == sq_idx_t'(SQUARE_SIDE - 1))
            r = '0;
        else
            r = v + sq_idx_t'(1);
        return r;
    endfunction

    // Last match in row-major order wins.
    function automatic loc_t locate(square_t sq, letter_t ch);
        loc_t l;
        l = '0;
        for (int i = 0; i < SQUARE_SIDE; i++)
        begin
            for (int j = 0; j < SQUARE_SIDE; j++)
            begin
                if (sq[i][j] == ch)
                begin
                    l.hit = 1'b1;
                    l.row = sq_idx_t'(i);
                    l.col = sq_idx_t'(j);
                end
            end
        end
        return l;
    endfunction

endpackage

FILE: rtl/pfd_letter_if.sv
// Plaintext letter channel: valid/ready handshake with one letter per beat.
// Depends on pfd_pkg.
interface pfd_letter_if;
    import pfd_pkg::*;

    logic    valid;
    logic    ready;
    letter_t letter;
    logic    last_item;

    modport source (output valid, output letter, output last_item, input ready);
    modport sink   (input valid, input letter, input last_item, output ready);

endinterface

FILE: rtl/pfd_cipher_if.sv
// Ciphertext pair channel: valid/ready handshake with one encrypted pair per beat.
// Depends on pfd_pkg.
interface pfd_cipher_if;
    import pfd_pkg::*;

    logic    valid;
    logic    ready;
    letter_t cipher_first;
    letter_t cipher_second;
    logic    not_in_square;
    logic    last_pair;

    modport source (output valid, output cipher_first, output cipher_second,
                    output not_in_square, output last_pair, input ready);
    modport sink   (input valid, input cipher_first, input cipher_second,
                    input not_in_square, input last_pair, output ready);

endinterface

FILE: rtl/pfd_pair.sv
// Letter pairing stage: holds the open letter and queues up to two pairs.
// Depends on pfd_pkg and the assertion macro header.
`include "playfair_digraph_encrypt_unit_macros.svh"

module pfd_pair (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  pfd_pkg::letter_t letter,
    input  logic            last_item,
    input  pfd_pkg::letter_t filler,
    output logic            pair_valid,
    input  logic            pair_ready,
    output pfd_pkg::pair_t  pair
);
    import pfd_pkg::*;

    letter_t held_letter_reg, held_letter_next;
    logic    held_valid_reg, held_valid_next;
    pair_t   p0_reg, p0_next, p1_reg, p1_next;
    logic    p0_valid_reg, p0_valid_next, p1_valid_reg, p1_valid_next;

    logic    in_fire, pop, repeat_hit;
    logic    gen_a, gen_b;
    pair_t   pa, pb;

    assign pop        = p0_valid_reg && pair_ready;
    assign in_ready   = !p1_valid_reg && (!p0_valid_reg || pair_ready);
    assign in_fire    = in_valid && in_ready;
    assign repeat_hit = held_valid_reg && (letter == held_letter_reg);

    assign pair_valid = p0_valid_reg;
    assign pair       = p0_reg;

    always_comb
    begin
        gen_a            = 1'b0;
        gen_b            = 1'b0;
        pa               = '{first: held_letter_reg, second: filler, last: 1'b0};
        pb               = '{first: letter, second: filler, last: 1'b1};
        held_letter_next = held_letter_reg;
        held_valid_next  = held_valid_reg;
        if (held_valid_reg)
        begin
            gen_a = 1'b1;
            if (repeat_hit)
            begin
                gen_b           = last_item;
                held_valid_next = !last_item;
            end
            else
            begin
                pa              = '{first: held_letter_reg, second: letter, last: last_item};
                held_valid_next = 1'b0;
            end
        end
        else if (last_item)
        begin
            gen_a = 1'b1;
            pa    = '{first: letter, second: filler, last: 1'b1};
        end
        else
        begin
            held_letter_next = letter;
            held_valid_next  = 1'b1;
        end
    end

    always_comb
    begin
        p0_next       = p0_reg;
        p1_next       = p1_reg;
        p0_valid_next = p0_valid_reg;
        p1_valid_next = p1_valid_reg;
        if (in_fire)
        begin
            p0_next       = pa;
            p1_next       = pb;
            p0_valid_next = gen_a;
            p1_valid_next = gen_b;
        end
        else if (pop)
        begin
            p0_next       = p1_reg;
            p0_valid_next = p1_valid_reg;
            p1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_letter_reg <= '0;
            held_valid_reg  <= 1'b0;
            p0_valid_reg    <= 1'b0;
            p1_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                held_letter_reg <= held_letter_next;
                held_valid_reg  <= held_valid_next;
            end
            p0_valid_reg <= p0_valid_next;
            p1_valid_reg <= p1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p0_reg <= p0_next;
        p1_reg <= p1_next;
    end

    `PFD_ASSERT_SAME(a_slot_order, p1_valid_reg, p0_valid_reg, "second pair slot without first")
    `PFD_ASSERT_NEXT(a_pair_closes, in_fire && held_valid_reg && !repeat_hit, !held_valid_reg, "held letter kept after closing pair")
    `PFD_ASSERT_NEXT(a_repeat_end, in_fire && repeat_hit && last_item, p0_valid_reg && p1_valid_reg && p1_reg.last && !p0_reg.last, "repeat at end did not queue two pairs")

endmodule

FILE: rtl/pfd_cipher.sv
// Pair encryption stage: locates both letters in the key square and registers the result.
// Depends on pfd_pkg and the assertion macro header.
`include "playfair_digraph_encrypt_unit_macros.svh"

module pfd_cipher (
    input  logic             clk,
    input  logic             rst_n,
    input  pfd_pkg::square_t square,
    input  logic             pair_valid,
    output logic             pair_ready,
    input  pfd_pkg::pair_t   pair,
    output logic             res_valid,
    input  logic             res_ready,
    output pfd_pkg::result_t res
);
    import pfd_pkg::*;

    result_t res_reg, res_next;
    logic    res_valid_reg;
    loc_t    loc_a, loc_b;
    logic    take;

    assign pair_ready = !res_valid_reg || res_ready;
    assign take       = pair_valid && pair_ready;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    always_comb
    begin
        loc_a                  = locate(square, pair.first);
        loc_b                  = locate(square, pair.second);
        res_next.cipher_first  = '0;
        res_next.cipher_second = '0;
        res_next.not_in_square = !(loc_a.hit && loc_b.hit);
        res_next.last_pair     = pair.last;
        if (loc_a.hit && loc_b.hit)
        begin
            if (loc_a.row == loc_b.row)
            begin
                res_next.cipher_first  = square[loc_a.row][wrap_inc(loc_a.col)];
                res_next.cipher_second = square[loc_b.row][wrap_inc(loc_b.col)];
            end
            else if (loc_a.col == loc_b.col)
            begin
                res_next.cipher_first  = square[wrap_inc(loc_a.row)][loc_a.col];
                res_next.cipher_second = square[wrap_inc(loc_b.row)][loc_b.col];
            end
            else
            begin
                res_next.cipher_first  = square[loc_a.row][loc_b.col];
                res_next.cipher_second = square[loc_b.row][loc_a.col];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (pair_ready)
            res_valid_reg <= pair_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            res_reg <= res_next;
    end

    `PFD_ASSERT_SAME(a_miss_zero, res_valid_reg && res_reg.not_in_square, res_reg.cipher_first == '0 && res_reg.cipher_second == '0, "missing letter with non-zero cipher")
    `PFD_ASSERT_NEXT(a_take_lands, take, res_valid_reg, "accepted pair did not reach result register")
    `PFD_ASSERT_NEXT(a_last_kept, take && pair.last, res_reg.last_pair, "last pair mark lost")

endmodule

FILE: rtl/playfair_digraph_encrypt_unit.sv
// Playfair digraph encryptor top level: configuration registers, pairing and cipher stages.
// Depends on pfd_pkg, pfd_letter_if, pfd_cipher_if, pfd_pair and pfd_cipher.
//
// Usage:
//   plaintext  : sink of letter beats (letter, last_item); one beat per cycle while ready is high.
//   ciphertext : source of pair beats (cipher_first, cipher_second,
//                not_in_square, last_pair).
//   cfg_write/cfg_index/cfg_data : register writes, taken on any edge with
//                cfg_write high; indexes 0..4 are key rows, 5 the filler letter,
//                others dropped. Write only while the block is idle.
// Path: the pair closed by a letter reaches ciphertext through the pair
//   slot, then the result register.
// Throughput: one letter per cycle while ciphertext is ready; a repeated letter
//   marked last yields two pairs and holds plaintext off until the second pair leaves its slot.
// Reset: key rows clear to zero, filler to 'x', no letter held, both
//   channels empty.
// Stall: when ciphertext is not ready the result register holds, the pair
//   slot fills, and plaintext ready drops until beats drain.
module playfair_digraph_encrypt_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    pfd_letter_if.sink                         plaintext,
    pfd_cipher_if.source                       ciphertext,
    input  logic                               cfg_write,
    input  logic [pfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pfd_pkg::ROW_W-1:0]          cfg_data
);
    import pfd_pkg::*;

    square_t key_reg;
    letter_t filler_reg;
    pair_t   pair;
    logic    pair_valid, pair_ready;
    result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg    <= '0;
            filler_reg <= FILLER_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_KEY_ROW0: key_reg[0] <= key_row_t'(cfg_data);
                REG_KEY_ROW1: key_reg[1] <= key_row_t'(cfg_data);
                REG_KEY_ROW2: key_reg[2] <= key_row_t'(cfg_data);
                REG_KEY_ROW3: key_reg[3] <= key_row_t'(cfg_data);
                REG_KEY_ROW4: key_reg[4] <= key_row_t'(cfg_data);
                REG_FILLER:   filler_reg <= cfg_data[LETTER_W-1:0];
                default:      ;
            endcase
        end
    end

    pfd_pair u_pair (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (plaintext.valid),
        .in_ready   (plaintext.ready),
        .letter     (plaintext.letter),
        .last_item  (plaintext.last_item),
        .filler     (filler_reg),
        .pair_valid (pair_valid),
        .pair_ready (pair_ready),
        .pair       (pair)
    );

    pfd_cipher u_cipher (
        .clk        (clk),
        .rst_n      (rst_n),
        .square     (key_reg),
        .pair_valid (pair_valid),
        .pair_ready (pair_ready),
        .pair       (pair),
        .res_valid  (ciphertext.valid),
        .res_ready  (ciphertext.ready),
        .res        (res)
    );

    assign ciphertext.cipher_first  = res.cipher_first;
    assign ciphertext.cipher_second = res.cipher_second;
    assign ciphertext.not_in_square = res.not_in_square;
    assign ciphertext.last_pair     = res.last_pair;

endmodule

FILE: bench/playfair_digraph_encrypt_unit_checker.sv
// Scoreboard for the Playfair digraph encryptor: follows key writes, pairs letter beats,
// predicts every cipher pair and compares it with the ciphertext channel.
// Depends on pfd_pkg, pfd_letter_if and pfd_cipher_if.
module playfair_digraph_encrypt_unit_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    pfd_letter_if                         plaintext,
    pfd_cipher_if                         ciphertext,
    input  logic                          cfg_write,
    input  logic [pfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pfd_pkg::ROW_W-1:0]     cfg_data,
    output int                            fail_count,
    output int                            pending_pairs,
    output int                            pairs_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import pfd_pkg::*;

    key_row_t key_rows [SQUARE_SIDE] = '{default: '0};
    letter_t  pad_letter = FILLER_RESET;
    letter_t  open_letter = '0;
    logic     open_valid = 1'b0;
    result_t  cipher_q [$];
    result_t  want;
    int       mismatches = 0;
    int       checked = 0;

    function automatic logic find_cell(input letter_t ch, output int row, output int col);
        logic hit;
        hit = 1'b0;
        row = 0;
        col = 0;
        for (int r = 0; r < SQUARE_SIDE; r++)
        begin
            for (int c = 0; c < SQUARE_SIDE; c++)
            begin
                if (key_rows[r][c] == ch)
                begin
                    hit = 1'b1;
                    row = r;
                    col = c;
                end
            end
        end
        return hit;
    endfunction

    function automatic result_t encrypt_pair(letter_t a, letter_t b, logic last);
        int      r1, c1, r2, c2;
        logic    hit_a, hit_b;
        result_t res;
        hit_a = find_cell(a, r1, c1);
        hit_b = find_cell(b, r2, c2);
        res = '0;
        res.last_pair = last;
        if (!(hit_a && hit_b))
            res.not_in_square = 1'b1;
        else if (r1 == r2)
        begin
            res.cipher_first  = key_rows[r1][(c1 + 1) % SQUARE_SIDE];
            res.cipher_second = key_rows[r2][(c2 + 1) % SQUARE_SIDE];
        end
        else if (c1 == c2)
        begin
            res.cipher_first  = key_rows[(r1 + 1) % SQUARE_SIDE][c1];
            res.cipher_second = key_rows[(r2 + 1) % SQUARE_SIDE][c2];
        end
        else
        begin
            res.cipher_first  = key_rows[r1][c2];
            res.cipher_second = key_rows[r2][c1];
        end
        return res;
    endfunction

    task automatic queue_pair(result_t r);
        cipher_q = {cipher_q, r};
    endtask

    task automatic take_letter(letter_t ch, logic last);
        if (open_valid)
        begin
            if (ch == open_letter)
            begin
                queue_pair(encrypt_pair(open_letter, pad_letter, 1'b0));
                if (last)
                begin
                    queue_pair(encrypt_pair(ch, pad_letter, 1'b1));
                    open_valid = 1'b0;
                    open_letter = '0;
                end
            end
            else
            begin
                queue_pair(encrypt_pair(open_letter, ch, last));
                open_valid = 1'b0;
                open_letter = '0;
            end
        end
        else if (last)
            queue_pair(encrypt_pair(ch, pad_letter, 1'b1));
        else
        begin
            open_letter = ch;
            open_valid = 1'b1;
        end
    endtask

    task automatic compare_field(string name, int expected, int actual);
        if (expected != actual)
        begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < SQUARE_SIDE; r++)
                key_rows[r] = '0;
            pad_letter = FILLER_RESET;
            open_letter = '0;
            open_valid = 1'b0;
            cipher_q.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index <= REG_KEY_ROW4)
                    key_rows[cfg_index] = cfg_data;
                else if (cfg_index == REG_FILLER)
                    pad_letter = cfg_data[LETTER_W-1:0];
            end
            if (plaintext.valid && plaintext.ready)
                take_letter(plaintext.letter, plaintext.last_item);
            if (ciphertext.valid && ciphertext.ready)
            begin
                if (cipher_q.size() == 0)
                begin
                    $error("cipher pair beat with no pair expected");
                    mismatches++;
                end
                else
                begin
                    want = cipher_q.pop_front();
                    compare_field("cipher_first", want.cipher_first, ciphertext.cipher_first);
                    compare_field("cipher_second", want.cipher_second,
                                  ciphertext.cipher_second);
                    compare_field("not_in_square", want.not_in_square,
                                  ciphertext.not_in_square);
                    compare_field("last_pair", want.last_pair, ciphertext.last_pair);
                    checked++;
                end
            end
        end
        fail_count <= mismatches;
        pending_pairs <= cipher_q.size();
        pairs_checked <= checked;
    end

endmodule

FILE: bench/playfair_digraph_encrypt_unit_tb.sv
// Top of the Playfair digraph encryptor bench: clock, reset, key squares, letter stream
// with bursts and gaps, ciphertext back-pressure and the verdict.
// Depends on pfd_pkg, both channel interfaces, the RTL and the checker module.
module playfair_digraph_encrypt_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfd_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_ITEMS = 650;
    localparam int PHASE_ITEMS  = 80;
    localparam int DRAIN_CYCLES = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef enum int {
        SQ_ORDERED,
        SQ_SHUFFLED,
        SQ_DISTINCT,
        SQ_REPEATS,
        SQ_ALL_ONES,
        SQ_ALL_ZERO
    } square_kind_t;

    typedef enum int {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_RARELY,
        RX_PATTERN,
        RX_STARVED
    } stall_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ROW_W-1:0]     cfg_data;

    pfd_letter_if plaintext();
    pfd_cipher_if ciphertext();

    int fail_count;
    int pending_pairs;
    int pairs_checked;
    int cycle_count = 0;
    int letters_sent = 0;
    int key_settings = 0;
    int burst_left = 0;
    bit gapless = 1'b0;

    key_row_t square [SQUARE_SIDE];
    letter_t  pad = FILLER_RESET;

    always #5ns clk = ~clk;

    playfair_digraph_encrypt_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .plaintext  (plaintext),
        .ciphertext (ciphertext),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    playfair_digraph_encrypt_unit_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .plaintext     (plaintext),
        .ciphertext    (ciphertext),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_pairs (pending_pairs),
        .pairs_checked (pairs_checked)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("playfair_digraph_encrypt_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        int          tick;
        stall_mode_t mode;
        tick = 0;
        mode = RX_ALWAYS;
        ciphertext.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (tick % 200 == 0)
                mode = stall_mode_t'($urandom_range(0, 4));
            case (mode)
                RX_ALWAYS:  ciphertext.ready <= 1'b1;
                RX_MOSTLY:  ciphertext.ready <= ($urandom_range(0, 3) != 0);
                RX_RARELY:  ciphertext.ready <= ($urandom_range(0, 3) == 0);
                RX_PATTERN: ciphertext.ready <= ((tick % 7) < 4);
                default:    ciphertext.ready <= ((tick % 24) == 0);
            endcase
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Drop valid, drain every expected pair, then give the pipeline time to empty.
    task automatic settle();
        plaintext.valid <= 1'b0;
        @(posedge clk);
        while (pending_pairs != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic rekey(square_kind_t kind);
        letter_t  cells [SQUARE_SIDE*SQUARE_SIDE];
        letter_t  pool [8];
        bit [255:0] used;
        letter_t  tmp;
        int       n;
        int       k;
        n = 0;
        used = '0;
        for (int i = 0; i < 8; i++)
            pool[i] = letter_t'($urandom);
        case (kind)
            SQ_ORDERED, SQ_SHUFFLED:
            begin
                for (int c = "a"; c <= "z"; c++)
                begin
                    if (c != "j")
                    begin
                        cells[n] = letter_t'(c);
                        n++;
                    end
                end
                if (kind == SQ_SHUFFLED)
                begin
                    for (int i = SQUARE_SIDE*SQUARE_SIDE - 1; i > 0; i--)
                    begin
                        k = $urandom_range(0, i);
                        tmp = cells[i];
                        cells[i] = cells[k];
                        cells[k] = tmp;
                    end
                    pad = $urandom_range(0, 1) ? FILLER_RESET : cells[$urandom_range(0, 24)];
                end
                else
                    pad = FILLER_RESET;
            end
            SQ_DISTINCT:
            begin
                for (int i = 0; i < SQUARE_SIDE*SQUARE_SIDE; i++)
                begin
                    do
                        tmp = letter_t'($urandom);
                    while (used[tmp]);
                    used[tmp] = 1'b1;
                    cells[i] = tmp;
                end
                pad = letter_t'($urandom);
            end
            SQ_REPEATS:
            begin
                for (int i = 0; i < SQUARE_SIDE*SQUARE_SIDE; i++)
                    cells[i] = pool[$urandom_range(0, 7)];
                pad = $urandom_range(0, 1) ? pool[$urandom_range(0, 7)] : letter_t'($urandom);
            end
            SQ_ALL_ONES:
            begin
                for (int i = 0; i < SQUARE_SIDE*SQUARE_SIDE; i++)
                    cells[i] = 8'hFF;
                pad = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default:
            begin
                for (int i = 0; i < SQUARE_SIDE*SQUARE_SIDE; i++)
                    cells[i] = 8'h00;
                pad = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
            end
        endcase
        for (int r = 0; r < SQUARE_SIDE; r++)
            for (int c = 0; c < SQUARE_SIDE; c++)
                square[r][c] = cells[r*SQUARE_SIDE + c];
        write_reg(REG_KEY_ROW0, square[0]);
        write_reg(REG_KEY_ROW1, square[1]);
        write_reg(REG_SPARE_A, ROW_W'({$urandom, $urandom}));
        write_reg(REG_KEY_ROW2, square[2]);
        write_reg(REG_KEY_ROW3, square[3]);
        write_reg(REG_KEY_ROW4, square[4]);
        write_reg(REG_FILLER, ROW_W'({$urandom, $urandom}) & ~ROW_W'(8'hFF) | ROW_W'(pad));
        write_reg(REG_SPARE_B, ROW_W'({$urandom, $urandom}));
        cfg_write <= 1'b0;
        key_settings++;
    endtask

    task automatic send_letter(letter_t ch, logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = gapless ? 0 : $urandom_range(0, 5);
            if (gap != 0)
            begin
                plaintext.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        plaintext.valid <= 1'b1;
        plaintext.letter <= ch;
        plaintext.last_item <= last;
        @(posedge clk);
        while (!plaintext.ready)
            @(posedge clk);
        letters_sent++;
    endtask

    function automatic letter_t pick_letter(letter_t prev);
        int      roll;
        letter_t ch;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            ch = square[$urandom_range(0, 4)][$urandom_range(0, 4)];
        else if (roll < 80)
            ch = prev;
        else if (roll < 87)
            ch = pad;
        else
            ch = letter_t'($urandom);
        return ch;
    endfunction

    initial
    begin
        string        directed_text;
        string        directed_ends;
        square_kind_t kind;
        int           phase;
        int           phase_sent;
        int           random_sent;
        int           len;
        letter_t      prev;
        letter_t      ch;

        directed_text = "eaavhyllommjaxxkqcd";
        directed_ends = "0000000000100000101";
        for (int r = 0; r < SQUARE_SIDE; r++)
            square[r] = '0;
        rst_n <= 1'b0;
        plaintext.valid <= 1'b0;
        plaintext.letter <= '0;
        plaintext.last_item <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset square: every cell zero, filler absent
        send_letter(8'h00, 1'b1);
        send_letter(8'hFF, 1'b0);
        send_letter(8'hFF, 1'b1);
        settle();

        rekey(SQ_ORDERED);
        for (int i = 0; i < directed_text.len(); i++)
            send_letter(letter_t'(directed_text[i]), directed_ends[i] == "1");
        send_letter(8'h00, 1'b0);
        send_letter(8'hFF, 1'b1);

        phase = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            settle();
            if (phase < 5)
                kind = square_kind_t'(SQ_SHUFFLED + phase);
            else if ($urandom_range(0, 3) == 0)
                kind = square_kind_t'($urandom_range(SQ_REPEATS, SQ_ALL_ZERO));
            else
                kind = square_kind_t'($urandom_range(SQ_SHUFFLED, SQ_DISTINCT));
            gapless = ($urandom_range(0, 3) == 0);
            rekey(kind);
            phase_sent = 0;
            prev = pad;
            while (phase_sent < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60)
                                                  : $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                begin
                    ch = pick_letter(prev);
                    send_letter(ch, i == len - 1);
                    prev = ch;
                end
                phase_sent += len;
            end
            random_sent += phase_sent;
            phase++;
        end
        settle();

        $display("Sent %0d letters under %0d key squares and checked %0d cipher pairs,",
                 letters_sent, key_settings, pairs_checked);
        $display("spanning reset, ordered, shuffled, distinct, repeated and uniform squares.");
        if (fail_count == 0 && pending_pairs == 0)
            $display("playfair_digraph_encrypt_unit regression: pass");
        else
            $display("playfair_digraph_encrypt_unit regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/pfd_pkg.sv
rtl/pfd_letter_if.sv
rtl/pfd_cipher_if.sv
rtl/pfd_pair.sv
rtl/pfd_cipher.sv
rtl/playfair_digraph_encrypt_unit.sv
bench/playfair_digraph_encrypt_unit_checker.sv
bench/playfair_digraph_encrypt_unit_tb.sv
